### rtl/core/dlle_pkg.sv
// Package: shared codes and state type of the doubly linked list engine.
`default_nettype none
package dlle_pkg;

   typedef enum logic [1:0] {
      OP_INSERT_FRONT = 2'd0,
      OP_INSERT_BACK  = 2'd1,
      OP_DELETE       = 2'd2,
      OP_UNUSED       = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_RSVD      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LINK,
      ST_WALK,
      ST_FETCH,
      ST_DONE
   } state_type;

   localparam int unsigned OUT_VALUE_BITS  = 32;
   localparam int unsigned OUT_LENGTH_BITS = 7;

endpackage
`default_nettype wire

### rtl/core/dlle_req_if.sv
// Interface: request channel (operation and value).
`default_nettype none
interface dlle_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic signed [31:0] value;

   modport source (output valid, output operation, output value, input ready);
   modport sink   (input valid, input operation, input value, output ready);
endinterface
`default_nettype wire

### rtl/core/dlle_rsp_if.sv
// Interface: response channel (status, length, head and tail values).
`default_nettype none
interface dlle_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [6:0]  list_length;
   logic signed [31:0] head_value;
   logic signed [31:0] tail_value;

   modport source (output valid, output status, output list_length,
                   output head_value, output tail_value, input ready);
   modport sink   (input valid, input status, input list_length,
                   input head_value, input tail_value, output ready);
endinterface
`default_nettype wire

### rtl/core/dlle_csr_if.sv
// Interface: configuration write channel (search direction).
`default_nettype none
interface dlle_csr_if;
   logic valid;
   logic ready;
   logic search_from_tail;

   modport source (output valid, output search_from_tail, input ready);
   modport sink   (input valid, input search_from_tail, output ready);
endinterface
`default_nettype wire

### rtl/core/dlle_node_store.sv
// Node pool memories: value, next and prev links with one registered read port.
`default_nettype none
module dlle_node_store #(
   parameter int unsigned NODE_CAPACITY = 64,
   parameter int unsigned VALUE_BITS    = 32,
   localparam int unsigned IW = (NODE_CAPACITY > 1) ? $clog2(NODE_CAPACITY) : 1
) (
   input  wire logic                  clock,
   input  wire logic [IW-1:0]         rd_addr,
   output logic [VALUE_BITS-1:0]      rd_value,
   output logic [IW-1:0]              rd_next,
   output logic [IW-1:0]              rd_prev,
   input  wire logic                  wr_value_en,
   input  wire logic [IW-1:0]         wr_value_addr,
   input  wire logic [VALUE_BITS-1:0] wr_value_data,
   input  wire logic                  wr_next_en,
   input  wire logic [IW-1:0]         wr_next_addr,
   input  wire logic [IW-1:0]         wr_next_data,
   input  wire logic                  wr_prev_en,
   input  wire logic [IW-1:0]         wr_prev_addr,
   input  wire logic [IW-1:0]         wr_prev_data
);

   logic [VALUE_BITS-1:0] value_mem [NODE_CAPACITY];
   logic [IW-1:0]         next_mem  [NODE_CAPACITY];
   logic [IW-1:0]         prev_mem  [NODE_CAPACITY];

   always_ff @(posedge clock) begin
      if (wr_value_en) begin
         value_mem[wr_value_addr] <= wr_value_data;
      end
      rd_value <= value_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_next_en) begin
         next_mem[wr_next_addr] <= wr_next_data;
      end
      rd_next <= next_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_prev_en) begin
         prev_mem[wr_prev_addr] <= wr_prev_data;
      end
      rd_prev <= prev_mem[rd_addr];
   end

endmodule
`default_nettype wire

### rtl/core/doubly_linked_list_engine_unit.sv
// Top level: doubly linked list engine with node pool and list sequencer.
`default_nettype none
// Usage:
//   req_if carries one word per operation: insert at front, insert at back,
//   or delete the first node holding a value. rsp_if returns one word per
//   request: status, list length, head value and tail value. csr_if writes
//   the search direction for deletes (0 head forward, 1 tail backward) and
//   is always ready; write it only while the engine is idle.
//   Path from an accepted request to the response word: an insert scans
//   the slot-used flags one slot per cycle for the lowest free slot, then
//   links the new node in. A full pool, an unused code or a delete on an
//   empty list goes straight to the done state. A delete walks the list one
//   node per cycle through the node memory read port; when the head or tail
//   node is removed, the new end value is then fetched in a further state.
//   The response sits in an output register; a new request is taken while
//   it waits. If the receiver stalls, the next finished response holds in
//   the done state until the output register frees up.
//   Reset (synchronous, active high) empties the pool and clears the
//   search direction; node memories are not cleared, only slots in the list
//   are ever read.
module doubly_linked_list_engine_unit #(
   parameter int unsigned NODE_CAPACITY = 64,
   parameter int unsigned VALUE_BITS    = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   dlle_req_if.sink   req_if,
   dlle_rsp_if.source rsp_if,
   dlle_csr_if.sink   csr_if
);

   localparam int unsigned IW = (NODE_CAPACITY > 1) ? $clog2(NODE_CAPACITY) : 1;
   localparam int unsigned CW = $clog2(NODE_CAPACITY + 1);
   localparam logic [CW-1:0] CAP_COUNT = CW'(NODE_CAPACITY);

   dlle_pkg::state_type state_ff, state_in;

   logic [1:0]            op_ff, op_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [IW-1:0]         first_ff, first_in;
   logic [IW-1:0]         last_ff, last_in;
   logic [VALUE_BITS-1:0] head_ff, head_in;
   logic [VALUE_BITS-1:0] tail_ff, tail_in;
   logic                  sft_ff, sft_in;
   logic [IW-1:0]         cur_ff, cur_in;
   logic [CW-1:0]         k_ff, k_in;
   logic                  fetch_head_ff, fetch_head_in;
   logic [1:0]            status_ff, status_in;
   logic                  used_ff [NODE_CAPACITY];
   logic                  used_in [NODE_CAPACITY];

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [6:0]            rsp_len_ff, rsp_len_in;
   logic [31:0]           rsp_head_ff, rsp_head_in;
   logic [31:0]           rsp_tail_ff, rsp_tail_in;

   // node store ports
   logic [IW-1:0]         rd_addr;
   logic [VALUE_BITS-1:0] rd_value;
   logic [IW-1:0]         rd_next, rd_prev;
   logic                  wr_value_en, wr_next_en, wr_prev_en;
   logic [IW-1:0]         wr_value_addr, wr_next_addr, wr_prev_addr;
   logic [VALUE_BITS-1:0] wr_value_data;
   logic [IW-1:0]         wr_next_data, wr_prev_data;

   logic                  req_fire;
   logic [63:0]           req_val64;
   logic [63:0]           head64, tail64;
   logic                  match;
   logic [IW-1:0]         link;

   dlle_node_store #(
      .NODE_CAPACITY(NODE_CAPACITY),
      .VALUE_BITS   (VALUE_BITS)
   ) u_store (
      .clock        (clock),
      .rd_addr      (rd_addr),
      .rd_value     (rd_value),
      .rd_next      (rd_next),
      .rd_prev      (rd_prev),
      .wr_value_en  (wr_value_en),
      .wr_value_addr(wr_value_addr),
      .wr_value_data(wr_value_data),
      .wr_next_en   (wr_next_en),
      .wr_next_addr (wr_next_addr),
      .wr_next_data (wr_next_data),
      .wr_prev_en   (wr_prev_en),
      .wr_prev_addr (wr_prev_addr),
      .wr_prev_data (wr_prev_data)
   );

   assign req_if.ready = (state_ff == dlle_pkg::ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign req_val64    = 64'(unsigned'(req_if.value));
   assign csr_if.ready = 1'b1;

   // the one shared compare: stored node value against the search key
   assign match = (rd_value == val_ff);
   // link followed by the walk, in the chosen direction
   assign link  = sft_ff ? rd_prev : rd_next;

   assign head64 = 64'(head_ff);
   assign tail64 = 64'(tail_ff);

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.list_length = rsp_len_ff;
   assign rsp_if.head_value  = rsp_head_ff;
   assign rsp_if.tail_value  = rsp_tail_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      cnt_in        = cnt_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      sft_in        = sft_ff;
      cur_in        = cur_ff;
      k_in          = k_ff;
      fetch_head_in = fetch_head_ff;
      status_in     = status_ff;
      used_in       = used_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_head_in   = rsp_head_ff;
      rsp_tail_in   = rsp_tail_ff;

      rd_addr       = cur_ff;
      wr_value_en   = 1'b0;
      wr_value_addr = cur_ff;
      wr_value_data = val_ff;
      wr_next_en    = 1'b0;
      wr_next_addr  = cur_ff;
      wr_next_data  = first_ff;
      wr_prev_en    = 1'b0;
      wr_prev_addr  = cur_ff;
      wr_prev_data  = last_ff;

      if (csr_if.valid) begin
         sft_in = csr_if.search_from_tail;
      end

      case (state_ff)
         dlle_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in  = req_if.operation;
               val_in = req_val64[VALUE_BITS-1:0];
               cur_in = '0;
               k_in   = '0;
               case (dlle_pkg::op_type'(req_if.operation))
                  dlle_pkg::OP_INSERT_FRONT, dlle_pkg::OP_INSERT_BACK: begin
                     if (cnt_ff >= CAP_COUNT) begin
                        status_in = dlle_pkg::STATUS_FULL;
                        state_in  = dlle_pkg::ST_DONE;
                     end else begin
                        state_in  = dlle_pkg::ST_SCAN;
                     end
                  end
                  dlle_pkg::OP_DELETE: begin
                     if (cnt_ff == '0) begin
                        status_in = dlle_pkg::STATUS_NOT_FOUND;
                        state_in  = dlle_pkg::ST_DONE;
                     end else begin
                        // start the walk: read the first node this cycle
                        cur_in   = sft_ff ? last_ff : first_ff;
                        rd_addr  = cur_in;
                        state_in = dlle_pkg::ST_WALK;
                     end
                  end
                  default: begin
                     status_in = dlle_pkg::STATUS_NOT_FOUND;
                     state_in  = dlle_pkg::ST_DONE;
                  end
               endcase
            end
         end

         dlle_pkg::ST_SCAN: begin
            // advance one slot a cycle to the lowest free slot
            if (!used_ff[cur_ff]) begin
               state_in = dlle_pkg::ST_LINK;
            end else begin
               cur_in = cur_ff + 1'b1;
            end
         end

         dlle_pkg::ST_LINK: begin
            used_in[cur_ff] = 1'b1;
            wr_value_en     = 1'b1;
            wr_value_addr   = cur_ff;
            wr_value_data   = val_ff;
            if (op_ff == dlle_pkg::OP_INSERT_FRONT) begin
               if (cnt_ff == '0) begin
                  last_in = cur_ff;
                  tail_in = val_ff;
               end else begin
                  wr_next_en   = 1'b1;
                  wr_next_addr = cur_ff;
                  wr_next_data = first_ff;
                  wr_prev_en   = 1'b1;
                  wr_prev_addr = first_ff;
                  wr_prev_data = cur_ff;
               end
               first_in = cur_ff;
               head_in  = val_ff;
            end else begin
               if (cnt_ff == '0) begin
                  first_in = cur_ff;
                  head_in  = val_ff;
               end else begin
                  wr_prev_en   = 1'b1;
                  wr_prev_addr = cur_ff;
                  wr_prev_data = last_ff;
                  wr_next_en   = 1'b1;
                  wr_next_addr = last_ff;
                  wr_next_data = cur_ff;
               end
               last_in = cur_ff;
               tail_in = val_ff;
            end
            cnt_in    = cnt_ff + 1'b1;
            status_in = dlle_pkg::STATUS_OK;
            state_in  = dlle_pkg::ST_DONE;
         end

         dlle_pkg::ST_WALK: begin
            // read data belongs to cur_ff
            if (match) begin
               used_in[cur_ff] = 1'b0;
               status_in       = dlle_pkg::STATUS_OK;
               state_in        = dlle_pkg::ST_DONE;
               if (cur_ff == first_ff && cur_ff == last_ff) begin
                  cnt_in   = '0;
                  first_in = '0;
                  last_in  = '0;
                  head_in  = '0;
                  tail_in  = '0;
               end else begin
                  cnt_in = cnt_ff - 1'b1;
                  if (cur_ff == first_ff) begin
                     first_in      = rd_next;
                     rd_addr       = rd_next;
                     fetch_head_in = 1'b1;
                     state_in      = dlle_pkg::ST_FETCH;
                  end else if (cur_ff == last_ff) begin
                     last_in       = rd_prev;
                     rd_addr       = rd_prev;
                     fetch_head_in = 1'b0;
                     state_in      = dlle_pkg::ST_FETCH;
                  end else begin
                     // unlink a middle node
                     wr_next_en   = 1'b1;
                     wr_next_addr = rd_prev;
                     wr_next_data = rd_next;
                     wr_prev_en   = 1'b1;
                     wr_prev_addr = rd_next;
                     wr_prev_data = rd_prev;
                  end
               end
            end else if (k_ff == cnt_ff - 1'b1) begin
               status_in = dlle_pkg::STATUS_NOT_FOUND;
               state_in  = dlle_pkg::ST_DONE;
            end else begin
               k_in     = k_ff + 1'b1;
               cur_in   = link;
               rd_addr  = link;
            end
         end

         dlle_pkg::ST_FETCH: begin
            if (fetch_head_ff) begin
               head_in = rd_value;
            end else begin
               tail_in = rd_value;
            end
            state_in = dlle_pkg::ST_DONE;
         end

         dlle_pkg::ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_len_in    = cnt_ff[CW-1:0] > 0 ? 7'(cnt_ff) : 7'd0;
               rsp_head_in   = head64[31:0];
               rsp_tail_in   = tail64[31:0];
               state_in      = dlle_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = dlle_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dlle_pkg::ST_IDLE;
         cnt_ff       <= '0;
         first_ff     <= '0;
         last_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         sft_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NODE_CAPACITY; i++) begin
            used_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         sft_ff       <= sft_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      cur_ff        <= cur_in;
      k_ff          <= k_in;
      fetch_head_ff <= fetch_head_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_tail_ff   <= rsp_tail_in;
   end

endmodule
`default_nettype wire
